>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file obbt_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on a clock, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on a clock that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/obbt_pkg.sv
// ----------------------------------------------------------------------------
// obbt_pkg
// widths, axis codes and pipeline control type for the box overlap test
// ----------------------------------------------------------------------------
package obbt_pkg;

  // field widths
  localparam int COORD_WIDTH = 32;
  localparam int SIZE_WIDTH  = 31;
  localparam int AXIS_WIDTH  = 16;

  // axis with one guard bit so that negating the most negative code is exact
  localparam int AXIS_EXT_W = AXIS_WIDTH + 1;

  // centre difference and its projections
  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int DPROD_W   = DIFF_W + AXIS_EXT_W;
  localparam int PROJ_W    = DPROD_W + 1;
  localparam int LHS_SHIFT = 15;
  localparam int LHS_W     = PROJ_W + LHS_SHIFT;

  // axis against axis products and their magnitudes
  localparam int APROD_W = 2 * AXIS_WIDTH;
  localparam int ADOT_W  = APROD_W;

  // projected extents
  localparam int SPROD_W   = SIZE_WIDTH + ADOT_W;
  localparam int OWN_SHIFT = 28;
  localparam int RHS_W     = SPROD_W + 2;

  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // the four candidate separating axes
  localparam int NUM_AXES   = 4;
  localparam int AX_A_RIGHT = 0;
  localparam int AX_A_UP    = 1;
  localparam int AX_B_RIGHT = 2;
  localparam int AX_B_UP    = 3;

  localparam int NUM_STAGES = 5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

>>> rtl/oriented_box_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_unit: separating axis test on two rotated boxes
// each input transaction passes through the five-stage multiply and compare
// pipeline; one transaction per cycle sustained while out_stall stays low
// reset clears only the stage valid bits, not the data path register state
// ----------------------------------------------------------------------------
module oriented_box_overlap_test_unit
  import obbt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] a_center_x,
  input  logic signed [COORD_WIDTH-1:0] a_center_y,
  input  logic        [SIZE_WIDTH-1:0]  a_width,
  input  logic        [SIZE_WIDTH-1:0]  a_height,
  input  logic signed [AXIS_WIDTH-1:0]  a_axis_x,
  input  logic signed [AXIS_WIDTH-1:0]  a_axis_y,
  input  logic signed [COORD_WIDTH-1:0] b_center_x,
  input  logic signed [COORD_WIDTH-1:0] b_center_y,
  input  logic        [SIZE_WIDTH-1:0]  b_width,
  input  logic        [SIZE_WIDTH-1:0]  b_height,
  input  logic signed [AXIS_WIDTH-1:0]  b_axis_x,
  input  logic signed [AXIS_WIDTH-1:0]  b_axis_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          overlap
);

  pipe_ctrl_t ctrl;

  obbt_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  // ---------------- stage 1: centre difference, axis products --------------
  logic signed [DIFF_W-1:0]     s1_dx, s1_dy;
  logic signed [AXIS_EXT_W-1:0] s1_ux [NUM_AXES];
  logic signed [AXIS_EXT_W-1:0] s1_uy [NUM_AXES];
  logic signed [APROD_W-1:0]    s1_pxx, s1_pyy, s1_pxy, s1_pyx;
  logic        [SIZE_WIDTH-1:0] s1_aw, s1_ah, s1_bw, s1_bh;

  logic signed [AXIS_EXT_W-1:0] ux_next [NUM_AXES];
  logic signed [AXIS_EXT_W-1:0] uy_next [NUM_AXES];
  logic signed [AXIS_EXT_W-1:0] ax_e, ay_e, bx_e, by_e;

  // up axis is the right axis turned by 90 degrees: (-y, x)
  always_comb begin
    ax_e = AXIS_EXT_W'(a_axis_x);
    ay_e = AXIS_EXT_W'(a_axis_y);
    bx_e = AXIS_EXT_W'(b_axis_x);
    by_e = AXIS_EXT_W'(b_axis_y);
    ux_next[AX_A_RIGHT] = ax_e;
    uy_next[AX_A_RIGHT] = ay_e;
    ux_next[AX_A_UP]    = -ay_e;
    uy_next[AX_A_UP]    = ax_e;
    ux_next[AX_B_RIGHT] = bx_e;
    uy_next[AX_B_RIGHT] = by_e;
    ux_next[AX_B_UP]    = -by_e;
    uy_next[AX_B_UP]    = bx_e;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_dx  <= DIFF_W'(b_center_x) - DIFF_W'(a_center_x);
      s1_dy  <= DIFF_W'(b_center_y) - DIFF_W'(a_center_y);
      s1_ux  <= ux_next;
      s1_uy  <= uy_next;
      s1_pxx <= APROD_W'(a_axis_x) * APROD_W'(b_axis_x);
      s1_pyy <= APROD_W'(a_axis_y) * APROD_W'(b_axis_y);
      s1_pxy <= APROD_W'(a_axis_x) * APROD_W'(b_axis_y);
      s1_pyx <= APROD_W'(a_axis_y) * APROD_W'(b_axis_x);
      s1_aw  <= a_width;
      s1_ah  <= a_height;
      s1_bw  <= b_width;
      s1_bh  <= b_height;
    end
  end

  // ---------------- stage 2: projection products, axis cos and sin ---------
  logic signed [DPROD_W-1:0]    s2_px [NUM_AXES];
  logic signed [DPROD_W-1:0]    s2_py [NUM_AXES];
  logic        [ADOT_W-1:0]     s2_c, s2_s;
  logic        [SIZE_WIDTH-1:0] s2_aw, s2_ah, s2_bw, s2_bh;

  logic signed [DPROD_W-1:0]    px_next [NUM_AXES];
  logic signed [DPROD_W-1:0]    py_next [NUM_AXES];
  logic signed [APROD_W:0]      c_sum, s_sum;
  logic        [ADOT_W-1:0]     c_next, s_next;

  // every box-to-box axis term reduces to |cos| or |sin| of the relative angle
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      px_next[k] = DPROD_W'(s1_dx) * DPROD_W'(s1_ux[k]);
      py_next[k] = DPROD_W'(s1_dy) * DPROD_W'(s1_uy[k]);
    end
    c_sum  = (APROD_W+1)'(s1_pxx) + (APROD_W+1)'(s1_pyy);
    s_sum  = (APROD_W+1)'(s1_pxy) - (APROD_W+1)'(s1_pyx);
    c_next = c_sum[APROD_W] ? ADOT_W'(-c_sum) : ADOT_W'(c_sum);
    s_next = s_sum[APROD_W] ? ADOT_W'(-s_sum) : ADOT_W'(s_sum);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_px <= px_next;
      s2_py <= py_next;
      s2_c  <= c_next;
      s2_s  <= s_next;
      s2_aw <= s1_aw;
      s2_ah <= s1_ah;
      s2_bw <= s1_bw;
      s2_bh <= s1_bh;
    end
  end

  // ---------------- stage 3: absolute projections, extent products --------
  logic [PROJ_W-1:0]     s3_pabs [NUM_AXES];
  logic [SPROD_W-1:0]    s3_mh   [NUM_AXES];
  logic [SPROD_W-1:0]    s3_mw   [NUM_AXES];
  logic [SIZE_WIDTH-1:0] s3_own  [NUM_AXES];

  logic signed [PROJ_W-1:0] proj    [NUM_AXES];
  logic [PROJ_W-1:0]        pabs_next [NUM_AXES];
  logic [SPROD_W-1:0]       mh_next [NUM_AXES];
  logic [SPROD_W-1:0]       mw_next [NUM_AXES];
  logic [SIZE_WIDTH-1:0]    own_next [NUM_AXES];
  logic [SIZE_WIDTH-1:0]    h_o, w_o;
  logic [ADOT_W-1:0]        sel_h, sel_w;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      proj[k]      = PROJ_W'(s2_px[k]) + PROJ_W'(s2_py[k]);
      pabs_next[k] = proj[k][PROJ_W-1] ? PROJ_W'(-proj[k]) : PROJ_W'(proj[k]);
      // extents of the other box
      h_o   = (k < AX_B_RIGHT) ? s2_bh : s2_ah;
      w_o   = (k < AX_B_RIGHT) ? s2_bw : s2_aw;
      // right axes see the other up axis through sin, up axes through cos
      sel_h = (k == AX_A_RIGHT || k == AX_B_RIGHT) ? s2_s : s2_c;
      sel_w = (k == AX_A_RIGHT || k == AX_B_RIGHT) ? s2_c : s2_s;
      mh_next[k] = SPROD_W'(h_o) * SPROD_W'(sel_h);
      mw_next[k] = SPROD_W'(w_o) * SPROD_W'(sel_w);
    end
    own_next[AX_A_RIGHT] = s2_aw;
    own_next[AX_A_UP]    = s2_ah;
    own_next[AX_B_RIGHT] = s2_bw;
    own_next[AX_B_UP]    = s2_bh;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_pabs <= pabs_next;
      s3_mh   <= mh_next;
      s3_mw   <= mw_next;
      s3_own  <= own_next;
    end
  end

  // ---------------- stage 4: both sides scaled to a common unit ------------
  logic [CMP_W-1:0] s4_lhs [NUM_AXES];
  logic [CMP_W-1:0] s4_rhs [NUM_AXES];

  logic [CMP_W-1:0] lhs_next [NUM_AXES];
  logic [CMP_W-1:0] rhs_next [NUM_AXES];

  // doubled sides in units of 2^-44, so the compare is exact
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      lhs_next[k] = CMP_W'(s3_pabs[k]) << LHS_SHIFT;
      rhs_next[k] = CMP_W'(s3_mh[k]) + CMP_W'(s3_mw[k])
                  + (CMP_W'(s3_own[k]) << OWN_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_lhs <= lhs_next;
      s4_rhs <= rhs_next;
    end
  end

  // ---------------- stage 5: compare and combine ---------------------------
  logic [NUM_AXES-1:0] sep;

  // touching boxes do not separate
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sep[k] = s4_lhs[k] > s4_rhs[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      overlap <= ~|sep;
    end
  end

endmodule

>>> rtl/obbt_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// obbt_pipe_ctrl
// valid bits and per-stage load enables; empty stages fill while the output
// is stalled
// ----------------------------------------------------------------------------
module obbt_pipe_ctrl
  import obbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_next;
  logic [NUM_STAGES-1:0] ready;

  // a stage may take new data when it is empty or its content moves on
  always_comb begin
    ready[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_comb begin
    ctrl.load[0]  = ready[0] && in_valid;
    valid_next[0] = ready[0] ? in_valid : valid[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      ctrl.load[k]  = ready[k] && valid[k-1];
      valid_next[k] = ready[k] ? valid[k-1] : valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

>>> rtl/obbt_checker.sv
// ----------------------------------------------------------------------------
// obbt_checker
// port-level checks on the box overlap test unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module obbt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic overlap
);

  `ASSERT_CLK(a_out_valid_held, clk, rst, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  `ASSERT_CLK(a_out_data_held, clk, rst, out_valid && out_stall |=> $stable(overlap), "stalled result changed")

  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result shown straight after reset")

  // an accepted transaction reaches the output when out_stall stays low behind it
  `ASSERT_CLK(a_latency, clk, rst, in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "accepted transaction did not reach the output")

endmodule

bind oriented_box_overlap_test_unit obbt_checker u_obbt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .overlap   (overlap)
);

>>> sim/oriented_box_overlap_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_unit_tb
// drives box pairs into the overlap tester and checks every overlap flag
// against an exact separating axis calculation done in 128-bit arithmetic;
// directed corner cases first, then random pairs under varying idle and
// stall patterns on both sides of the handshake
// ----------------------------------------------------------------------------
module oriented_box_overlap_test_unit_tb;
  import obbt_pkg::*;

  localparam int LATENCY     = 5;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 500;
  localparam int NUM_PHASES  = 4;
  localparam int ONE         = 65536;
  localparam int UNIT        = 16384;
  localparam int SIZE_MAX    = 2147483647;
  localparam int COORD_MIN   = 32'sh8000_0000;
  localparam int COORD_MAX   = 32'sh7fff_ffff;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [SIZE_WIDTH-1:0]  extent_t;
  typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
  typedef logic signed [127:0]           wide_t;

  typedef struct {
    coord_t  cx, cy;
    extent_t w, h;
    axis_t   ux, uy;
  } box_t;

  typedef struct {
    box_t a, b;
  } box_pair_t;

  class overlap_scoreboard;
    bit expected_overlap[$];
    int failures;

    function wide_t magnitude(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    // doubled and scaled to 2^-44 so the comparison is exact
    function bit axis_separates(wide_t dx, wide_t dy, wide_t ux, wide_t uy, wide_t own,
                                wide_t ox, wide_t oy, wide_t ow, wide_t oh);
      wide_t gap, reach;
      gap   = magnitude(dx * ux + dy * uy) << 15;
      reach = oh * magnitude(uy * ox - ux * oy) + ow * magnitude(ux * ox + uy * oy)
            + (own << 28);
      return gap > reach;
    endfunction

    function bit boxes_overlap(box_pair_t p);
      wide_t dx, dy, aux, auy, bux, buy;
      dx  = wide_t'(p.b.cx) - wide_t'(p.a.cx);
      dy  = wide_t'(p.b.cy) - wide_t'(p.a.cy);
      aux = p.a.ux;
      auy = p.a.uy;
      bux = p.b.ux;
      buy = p.b.uy;
      return !(axis_separates(dx, dy, aux, auy, p.a.w, bux, buy, p.b.w, p.b.h)
            || axis_separates(dx, dy, -auy, aux, p.a.h, bux, buy, p.b.w, p.b.h)
            || axis_separates(dx, dy, bux, buy, p.b.w, aux, auy, p.a.w, p.a.h)
            || axis_separates(dx, dy, -buy, bux, p.b.h, aux, auy, p.a.w, p.a.h));
    endfunction

    function void note_pair(box_pair_t p);
      expected_overlap.push_back(boxes_overlap(p));
    endfunction

    function void check_overlap(logic got);
      bit want;
      if (expected_overlap.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: overlap %b arrived with no transaction pending", got);
      end else begin
        want = expected_overlap.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: overlap expected %b, got %b", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_overlap.size();
    endfunction
  endclass

  logic    clk        = 1'b0;
  logic    rst        = 1'b1;
  logic    in_valid   = 1'b0;
  logic    in_stall;
  coord_t  a_center_x = '0;
  coord_t  a_center_y = '0;
  extent_t a_width    = '0;
  extent_t a_height   = '0;
  axis_t   a_axis_x   = '0;
  axis_t   a_axis_y   = '0;
  coord_t  b_center_x = '0;
  coord_t  b_center_y = '0;
  extent_t b_width    = '0;
  extent_t b_height   = '0;
  axis_t   b_axis_x   = '0;
  axis_t   b_axis_y   = '0;
  logic    out_valid;
  logic    out_stall  = 1'b0;
  logic    overlap;

  overlap_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  oriented_box_overlap_test_unit u_top (.*);

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall = !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    box_pair_t seen;
    bit        moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen.a = '{a_center_x, a_center_y, a_width, a_height, a_axis_x, a_axis_y};
        seen.b = '{b_center_x, b_center_y, b_width, b_height, b_axis_x, b_axis_y};
        sb.note_pair(seen);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_overlap(overlap);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL oriented_box_overlap_test_unit");
        $finish;
      end
    end
  end

  function automatic box_t make_box(int cx, int cy, int w, int h, int ux, int uy);
    box_t bx;
    bx.cx = cx;
    bx.cy = cy;
    bx.w  = extent_t'(w);
    bx.h  = extent_t'(h);
    bx.ux = axis_t'(ux);
    bx.uy = axis_t'(uy);
    return bx;
  endfunction

  function automatic box_t noise_box();
    return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // unit direction, rounded toward zero onto the Q2.14 grid
  function automatic void unit_axis(output axis_t ux, output axis_t uy);
    int x, y;
    x = int'($urandom_range(2 * UNIT)) - UNIT;
    y = $rtoi($sqrt(real'(UNIT * UNIT) - real'(x * x)));
    if ($urandom_range(1)) y = -y;
    ux = axis_t'(x);
    uy = axis_t'(y);
  endfunction

  // mostly nearby boxes of a random scale so both outcomes stay common
  function automatic box_pair_t random_pair();
    box_pair_t p;
    int        span;
    if ($urandom_range(99) < 15) begin
      p.a = noise_box();
      p.b = noise_box();
      return p;
    end
    span   = 1 << $urandom_range(4, 24);
    p.a.cx = $signed($urandom) >>> 2;
    p.a.cy = $signed($urandom) >>> 2;
    p.b.cx = p.a.cx + int'($urandom_range(4 * span)) - 2 * span;
    p.b.cy = p.a.cy + int'($urandom_range(4 * span)) - 2 * span;
    p.a.w  = extent_t'($urandom_range(2 * span));
    p.a.h  = extent_t'($urandom_range(2 * span));
    p.b.w  = extent_t'($urandom_range(2 * span));
    p.b.h  = extent_t'($urandom_range(2 * span));
    unit_axis(p.a.ux, p.a.uy);
    unit_axis(p.b.ux, p.b.uy);
    if ($urandom_range(9) == 0) begin
      // not normalised
      p.a.ux = axis_t'(int'($urandom_range(2 * UNIT)) - UNIT);
      p.b.uy = axis_t'(int'($urandom_range(2 * UNIT)) - UNIT);
    end
    return p;
  endfunction

  task automatic send_pair(box_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    a_center_x = p.a.cx;
    a_center_y = p.a.cy;
    a_width    = p.a.w;
    a_height   = p.a.h;
    a_axis_x   = p.a.ux;
    a_axis_y   = p.a.uy;
    b_center_x = p.b.cx;
    b_center_y = p.b.cy;
    b_width    = p.b.w;
    b_height   = p.b.h;
    b_axis_x   = p.b.ux;
    b_axis_y   = p.b.uy;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // sender holds off until every pending flag has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  initial begin
    box_pair_t directed[$];
    int        idle_by_phase[NUM_PHASES];
    int        stall_by_phase[NUM_PHASES];
    idle_by_phase  = '{0, 75, 0, 31};
    stall_by_phase = '{0, 0, 75, 31};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // touching edges count as overlap, one lsb further apart does not
    directed.push_back('{make_box(0, 0, 2*ONE, 2*ONE, UNIT, 0),
                         make_box(0, 0, 2*ONE, 2*ONE, UNIT, 0)});
    directed.push_back('{make_box(0, 0, 2*ONE, 2*ONE, UNIT, 0),
                         make_box(2*ONE, 0, 2*ONE, 2*ONE, UNIT, 0)});
    directed.push_back('{make_box(0, 0, 2*ONE, 2*ONE, UNIT, 0),
                         make_box(2*ONE + 1, 0, 2*ONE, 2*ONE, UNIT, 0)});
    directed.push_back('{make_box(0, 0, 4*ONE, 2*ONE, 0, UNIT),
                         make_box(0, 3*ONE, 2*ONE, 2*ONE, UNIT, 0)});
    directed.push_back('{make_box(0, 0, 4*ONE, 2*ONE, 0, UNIT),
                         make_box(0, 3*ONE + 1, 2*ONE, 2*ONE, UNIT, 0)});
    directed.push_back('{make_box(0, 0, 2*ONE, 2*ONE, 11585, 11585),
                         make_box(2*ONE, 2*ONE, 2*ONE, 2*ONE, UNIT, 0)});
    directed.push_back('{make_box(ONE, -ONE, 3*ONE, ONE, -UNIT, 0),
                         make_box(-ONE, ONE, ONE, 3*ONE, 0, -UNIT)});
    // degenerate sizes and axes
    directed.push_back('{make_box(5, 5, 0, 0, UNIT, 0), make_box(5, 5, 0, 0, 0, UNIT)});
    directed.push_back('{make_box(5, 5, 0, 0, UNIT, 0), make_box(6, 5, 0, 0, 0, UNIT)});
    directed.push_back('{make_box(0, 0, ONE, ONE, 0, 0),
                         make_box(100*ONE, 0, ONE, ONE, 0, 0)});
    directed.push_back('{make_box(0, 0, 2*ONE, ONE, -32768, -32768),
                         make_box(ONE, ONE, ONE, 2*ONE, -32768, -32768)});
    directed.push_back('{make_box(0, 0, 2*ONE, ONE, 32767, 32767),
                         make_box(-ONE, ONE, ONE, 2*ONE, 32767, -32768)});
    // extremes of the coordinate and size range
    directed.push_back('{make_box(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, UNIT, 0),
                         make_box(COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, UNIT, 0)});
    directed.push_back('{make_box(COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX, 0, -UNIT),
                         make_box(COORD_MIN, COORD_MAX, SIZE_MAX, SIZE_MAX, -UNIT, 0)});
    directed.push_back('{make_box(COORD_MIN, COORD_MAX, 0, 0, -32768, 32767),
                         make_box(COORD_MAX, COORD_MIN, SIZE_MAX, 0, 32767, -32768)});
    directed.push_back('{make_box(-1, -1, SIZE_MAX, SIZE_MAX, -1, -1),
                         make_box(-1, -1, SIZE_MAX, SIZE_MAX, -1, -1)});
    directed.push_back('{make_box(0, 0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 0, 0)});
    directed.push_back('{make_box(COORD_MIN, 0, SIZE_MAX, 1, UNIT, 0),
                         make_box(0, 0, 1, SIZE_MAX, 0, UNIT)});

    foreach (directed[i]) send_pair(directed[i]);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      repeat (PHASE_ITEMS) send_pair(random_pair());
      wait_drained();
    end

    if (sb.failures == 0 && sb.pending() == 0)
      $display("PASS oriented_box_overlap_test_unit");
    else
      $display("FAIL oriented_box_overlap_test_unit");
    $finish;
  end

endmodule
